>>> src/twims_pkg.sv
// Shared types, codes and helpers for the two-wire bus sequencer.
`default_nettype none
package twims_pkg;

	typedef enum logic [2:0] {
		CMD_START_WR = 3'd0,
		CMD_START_RD = 3'd1,
		CMD_EVENT    = 3'd2,
		CMD_LOAD     = 3'd3,
		CMD_ABORT    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_MT   = 3'd1,
		MODE_MR   = 3'd2,
		MODE_SR   = 3'd3,
		MODE_ST   = 3'd4
	} mode_t;

	localparam logic CFG_RX_LIMIT  = 1'b0;
	localparam logic CFG_TX_LENGTH = 1'b1;

	localparam logic [7:0] ST_START              = 8'h08;
	localparam logic [7:0] ST_RSTART             = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK         = 8'h18;
	localparam logic [7:0] ST_MT_SLA_NACK        = 8'h20;
	localparam logic [7:0] ST_MT_DATA_ACK        = 8'h28;
	localparam logic [7:0] ST_MT_DATA_NACK       = 8'h30;
	localparam logic [7:0] ST_ARB_LOST           = 8'h38;
	localparam logic [7:0] ST_MR_SLA_ACK         = 8'h40;
	localparam logic [7:0] ST_MR_SLA_NACK        = 8'h48;
	localparam logic [7:0] ST_MR_DATA_ACK        = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NACK       = 8'h58;
	localparam logic [7:0] ST_SR_SLA_ACK         = 8'h60;
	localparam logic [7:0] ST_SR_ARB_SLA_ACK     = 8'h68;
	localparam logic [7:0] ST_SR_GCALL_ACK       = 8'h70;
	localparam logic [7:0] ST_SR_ARB_GCALL_ACK   = 8'h78;
	localparam logic [7:0] ST_SR_DATA_ACK        = 8'h80;
	localparam logic [7:0] ST_SR_DATA_NACK       = 8'h88;
	localparam logic [7:0] ST_SR_GCALL_DATA_ACK  = 8'h90;
	localparam logic [7:0] ST_SR_GCALL_DATA_NACK = 8'h98;
	localparam logic [7:0] ST_SR_STOP            = 8'hA0;
	localparam logic [7:0] ST_ST_SLA_ACK         = 8'hA8;
	localparam logic [7:0] ST_ST_ARB_SLA_ACK     = 8'hB0;
	localparam logic [7:0] ST_ST_DATA_ACK        = 8'hB8;
	localparam logic [7:0] ST_ST_DATA_NACK       = 8'hC0;
	localparam logic [7:0] ST_ST_LAST_DATA       = 8'hC8;
	localparam logic [7:0] ST_NO_INFO            = 8'hF8;

	localparam logic [7:0] IDLE_FILL = 8'hFF;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] target_address;
		logic       use_register;
		logic [7:0] register_address;
		logic [7:0] transfer_length;
		logic [7:0] bus_status;
		logic [7:0] bus_byte;
		logic [4:0] buffer_slot;
	} req_item_t;

	typedef struct packed {
		logic [7:0] drive_byte;
		logic       drive_valid;
		logic       send_start;
		logic       send_stop;
		logic       ack_enable;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic [2:0] iface_state;
		logic [7:0] byte_count;
		logic       transfer_done;
		logic       busy_reject;
	} res_item_t;

	function automatic logic [7:0] bump8(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage
`default_nettype wire

>>> src/twi_master_slave_sequencer.sv
// Top level of the two-wire bus sequencer: request register, sequencer, result register.
`default_nettype none
// One request enters per clock while the result port is not stalled; its result is
// presented on the result port from the result register: the request register
// feeds the status decode and state update, whose outcome lands in the result
// register. The sustained rate is one request per cycle while res_ready is held,
// set by the combinational decode and the one-ahead read of the
// transmit store, which always holds the byte at the current send index.
// The transmit store has a valid bit per entry cleared at reset, so no clearing
// pass is needed and requests are taken from the first cycle after reset.
module twi_master_slave_sequencer
	import twims_pkg::*;
#(
	parameter int TX_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_item_t  req,
	output logic            res_valid,
	input  wire logic       res_ready,
	output res_item_t       res,
	input  wire logic       cfg_write,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	req_item_t  req_s1;
	logic       vld_s1;
	res_item_t  res_q;
	logic       res_vld_q;
	res_item_t  res_d;
	logic       fire;
	logic       wr_en;
	logic [7:0] rd_index;
	logic [7:0] rd_byte;
	logic [7:0] head_byte;

	assign fire      = vld_s1 && (!res_vld_q || res_ready);
	assign req_ready = !vld_s1 || fire;

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				res_vld_q <= 1'b1;
			end else if (res_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	twims_seq #(
		.TX_DEPTH(TX_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (req_s1),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_byte   (rd_byte),
		.head_byte (head_byte),
		.res       (res_d),
		.wr_en     (wr_en),
		.rd_index  (rd_index)
	);

	twims_tx_buffer #(
		.TX_DEPTH(TX_DEPTH)
	) u_txbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en && fire),
		.wr_slot   (req_s1.buffer_slot),
		.wr_data   (req_s1.bus_byte),
		.rd_index  (rd_index),
		.rd_byte   (rd_byte),
		.head_byte (head_byte)
	);

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule
`default_nettype wire

>>> src/twims_tx_buffer.sv
// Transmit byte store with per-entry valid bits and a one-ahead registered read.
`default_nettype none
module twims_tx_buffer
	import twims_pkg::*;
#(
	parameter int TX_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire logic [4:0] wr_slot,
	input  wire logic [7:0] wr_data,
	input  wire logic [7:0] rd_index,
	output logic      [7:0] rd_byte,
	output logic      [7:0] head_byte
);

	localparam int         AW     = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam logic [8:0] DEPTH9 = 9'(TX_DEPTH);

	logic [7:0]          mem [TX_DEPTH];
	logic [TX_DEPTH-1:0] vld_q;
	logic [7:0]          rdata_q;
	logic                rvld_q;
	logic [7:0]          head_q;
	logic                wr_ok;
	logic                rd_ok;
	logic                wr_hit;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;

	assign wr_ok   = wr_en && ({4'b0, wr_slot} < DEPTH9);
	assign rd_ok   = {1'b0, rd_index} < DEPTH9;
	assign wr_addr = AW'(wr_slot);
	assign rd_addr = AW'(rd_index);
	assign wr_hit  = wr_ok && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= wr_hit ? wr_data : mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
			head_q <= '0;
		end else begin
			if (wr_ok) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rvld_q <= rd_ok && (wr_hit || vld_q[rd_addr]);
			if (wr_ok && (wr_slot == 5'd0)) begin
				head_q <= wr_data;
			end
		end
	end

	assign rd_byte   = rvld_q ? rdata_q : 8'h00;
	assign head_byte = head_q;

endmodule
`default_nettype wire

>>> src/twims_seq.sv
// Sequencer state, configuration registers and status decode.
`default_nettype none
module twims_seq
	import twims_pkg::*;
#(
	parameter int TX_DEPTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire req_item_t item,
	input  wire logic      cfg_write,
	input  wire logic      cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic [7:0] rd_byte,
	input  wire logic [7:0] head_byte,
	output res_item_t      res,
	output logic           wr_en,
	output logic     [7:0] rd_index
);

	localparam int         SLW    = $clog2(TX_DEPTH + 1);
	localparam logic [8:0] DEPTH9 = 9'(TX_DEPTH);

	mode_t          mode_q, mode_d;
	logic [7:0]     addr_byte_q, addr_byte_d;
	logic           reg_pend_q, reg_pend_d;
	logic [7:0]     held_reg_q, held_reg_d;
	logic [7:0]     send_idx_q, send_idx_d;
	logic [SLW-1:0] send_len_q, send_len_d;
	logic [7:0]     recv_idx_q, recv_idx_d;
	logic [7:0]     recv_len_q, recv_len_d;
	logic [7:0]     rx_limit_q;
	logic [5:0]     tx_len_q;

	logic [7:0]     status;
	logic [SLW-1:0] mt_len_sat;
	logic [SLW-1:0] st_len_sat;
	logic [7:0]     tx_cur;
	logic [7:0]     tx_first;
	logic [7:0]     st_idx;
	mode_t          ref_mode;

	assign status     = {item.bus_status[7:3], 3'b000};
	assign mt_len_sat = ({1'b0, item.transfer_length} < DEPTH9) ?
		SLW'(item.transfer_length) : SLW'(TX_DEPTH);
	assign st_len_sat = ({3'b0, tx_len_q} < DEPTH9) ? SLW'(tx_len_q) : SLW'(TX_DEPTH);
	assign tx_cur     = ({1'b0, send_idx_q} < 9'(send_len_q)) ? rd_byte : IDLE_FILL;
	assign tx_first   = (st_len_sat != '0) ? head_byte : IDLE_FILL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			addr_byte_q <= '0;
			reg_pend_q  <= 1'b0;
			held_reg_q  <= '0;
			send_idx_q  <= '0;
			send_len_q  <= '0;
			recv_idx_q  <= '0;
			recv_len_q  <= '0;
		end else if (fire) begin
			mode_q      <= mode_d;
			addr_byte_q <= addr_byte_d;
			reg_pend_q  <= reg_pend_d;
			held_reg_q  <= held_reg_d;
			send_idx_q  <= send_idx_d;
			send_len_q  <= send_len_d;
			recv_idx_q  <= recv_idx_d;
			recv_len_q  <= recv_len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_limit_q <= '0;
			tx_len_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_RX_LIMIT:  rx_limit_q <= cfg_data;
				CFG_TX_LENGTH: tx_len_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_d      = mode_q;
		addr_byte_d = addr_byte_q;
		reg_pend_d  = reg_pend_q;
		held_reg_d  = held_reg_q;
		send_idx_d  = send_idx_q;
		send_len_d  = send_len_q;
		recv_idx_d  = recv_idx_q;
		recv_len_d  = recv_len_q;
		res         = '0;
		st_idx      = send_idx_q;
		wr_en       = 1'b0;

		unique case (item.command)
			CMD_START_WR, CMD_START_RD: begin
				if (mode_q != MODE_IDLE) begin
					res.busy_reject = 1'b1;
				end else begin
					addr_byte_d = {item.target_address, item.command[0]};
					reg_pend_d  = item.use_register;
					held_reg_d  = item.register_address;
					if (item.command == CMD_START_WR) begin
						mode_d     = MODE_MT;
						send_idx_d = '0;
						send_len_d = mt_len_sat;
					end else begin
						mode_d     = MODE_MR;
						recv_idx_d = '0;
						recv_len_d = item.transfer_length;
					end
					res.send_start = 1'b1;
				end
			end
			CMD_LOAD: begin
				wr_en = 1'b1;
			end
			CMD_ABORT: begin
				send_idx_d     = '0;
				send_len_d     = '0;
				recv_idx_d     = '0;
				recv_len_d     = '0;
				reg_pend_d     = 1'b0;
				mode_d         = MODE_IDLE;
				res.ack_enable = 1'b1;
			end
			CMD_EVENT: begin
				unique case (status)
					ST_START, ST_RSTART: begin
						res.drive_valid = 1'b1;
						res.drive_byte  = reg_pend_q ? {addr_byte_q[7:1], 1'b0} : addr_byte_q;
					end
					ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
						if (reg_pend_q) begin
							res.drive_valid = 1'b1;
							if (mode_q == MODE_MR && status == ST_MT_DATA_ACK) begin
								reg_pend_d     = 1'b0;
								res.send_start = 1'b1;
								res.drive_byte = {addr_byte_q[7:1], 1'b1};
							end else begin
								if (mode_q != MODE_MR) begin
									reg_pend_d = 1'b0;
								end
								res.drive_byte = held_reg_q;
							end
						end else if ({1'b0, send_idx_q} < 9'(send_len_q)) begin
							res.drive_valid = 1'b1;
							res.drive_byte  = tx_cur;
							send_idx_d      = bump8(send_idx_q);
						end else begin
							res.send_stop  = 1'b1;
							res.ack_enable = 1'b1;
							mode_d         = MODE_IDLE;
						end
					end
					ST_MR_DATA_NACK: begin
						res.rx_byte    = item.bus_byte;
						res.rx_valid   = 1'b1;
						recv_idx_d     = bump8(recv_idx_q);
						res.send_stop  = 1'b1;
						res.ack_enable = 1'b1;
						mode_d         = MODE_IDLE;
					end
					ST_MR_SLA_NACK, ST_MT_SLA_NACK, ST_MT_DATA_NACK: begin
						res.send_stop  = 1'b1;
						res.ack_enable = 1'b1;
						mode_d         = MODE_IDLE;
					end
					ST_ARB_LOST, ST_SR_STOP, ST_ST_DATA_NACK, ST_ST_LAST_DATA: begin
						res.ack_enable = 1'b1;
						mode_d         = MODE_IDLE;
					end
					ST_MR_DATA_ACK, ST_MR_SLA_ACK: begin
						if (status == ST_MR_DATA_ACK) begin
							res.rx_byte  = item.bus_byte;
							res.rx_valid = 1'b1;
							recv_idx_d   = bump8(recv_idx_q);
						end
						res.ack_enable = ({1'b0, recv_idx_d} + 9'd1) < {1'b0, recv_len_q};
					end
					ST_SR_SLA_ACK, ST_SR_ARB_SLA_ACK, ST_SR_GCALL_ACK,
					ST_SR_ARB_GCALL_ACK: begin
						mode_d         = MODE_SR;
						recv_idx_d     = '0;
						recv_len_d     = rx_limit_q;
						res.ack_enable = 1'b1;
					end
					ST_SR_DATA_ACK, ST_SR_GCALL_DATA_ACK: begin
						if (recv_idx_q < recv_len_q) begin
							res.rx_byte  = item.bus_byte;
							res.rx_valid = 1'b1;
							recv_idx_d   = bump8(recv_idx_q);
						end
						res.ack_enable = recv_idx_d < recv_len_q;
					end
					ST_SR_DATA_NACK, ST_SR_GCALL_DATA_NACK, ST_NO_INFO: begin
					end
					ST_ST_SLA_ACK, ST_ST_ARB_SLA_ACK, ST_ST_DATA_ACK: begin
						res.drive_valid = 1'b1;
						if (status != ST_ST_DATA_ACK) begin
							mode_d         = MODE_ST;
							send_len_d     = st_len_sat;
							st_idx         = '0;
							res.drive_byte = tx_first;
						end else begin
							res.drive_byte = tx_cur;
						end
						send_idx_d     = bump8(st_idx);
						res.ack_enable = {1'b0, send_idx_d} < 9'(send_len_d);
					end
					default: begin
						res.send_stop  = 1'b1;
						res.ack_enable = 1'b1;
						mode_d         = MODE_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase

		ref_mode = (mode_d != MODE_IDLE) ? mode_d : mode_q;
		unique case (ref_mode)
			MODE_MT, MODE_ST: res.byte_count = send_idx_d;
			MODE_MR, MODE_SR: res.byte_count = recv_idx_d;
			default:          res.byte_count = '0;
		endcase
		res.iface_state   = mode_d;
		res.transfer_done = (mode_q != MODE_IDLE) && (mode_d == MODE_IDLE);
	end

	assign rd_index = fire ? send_idx_d : send_idx_q;

endmodule
`default_nettype wire

>>> src/twims_checker.sv
// Port-level checks for the two-wire bus sequencer and their binding.
`default_nettype none
module twims_checker
	import twims_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      res_valid,
	input wire logic      res_ready,
	input wire res_item_t res
);

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.transfer_done |-> res.iface_state == MODE_IDLE)
		else $error("done reported with interface not idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.busy_reject |-> !res.send_start && !res.drive_valid && !res.send_stop)
		else $error("rejected start produced bus activity");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.rx_valid |-> !res.drive_valid)
		else $error("receive and drive in the same result");

endmodule

bind twi_master_slave_sequencer twims_checker u_twims_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
`default_nettype wire
